[rtl/mlrr_pkg.sv]
// Package for the multi-lane bus round-robin arbiter.
// Holds payload structs, fixed field widths, reset values and register codes.
// No dependencies.
`timescale 1ns / 1ps

package mlrr_pkg;

  // Fixed field widths of the ports
  localparam int MASK_W      = 16;
  localparam int LANE_FREE_W = 4;
  localparam int REQ_W       = 4;
  localparam int OUT_LANE_W  = 2;
  localparam int SC_W        = 5;
  localparam int LC_W        = 3;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT   = 1'd1;

  // Configuration reset values
  localparam logic [SC_W-1:0] SOURCE_COUNT_RST = 5'd16;
  localparam logic [LC_W-1:0] LANE_COUNT_RST   = 3'd1;

  // One grant query
  typedef struct packed {
    logic                   new_cycle;
    logic [REQ_W-1:0]       requester;
    logic [MASK_W-1:0]      head_present;
    logic [MASK_W-1:0]      head_ready;
    logic [MASK_W-1:0]      read_ready;
    logic [LANE_FREE_W-1:0] lane_free;
  } mlrr_in_t;

  // One grant answer
  typedef struct packed {
    logic                  granted;
    logic [OUT_LANE_W-1:0] lane;
  } mlrr_out_t;

endpackage

[rtl/mlrr_front.sv]
// Front end of the arbiter: accepts queries and classifies them into queue entries.
// Depends on mlrr_pkg.
`timescale 1ns / 1ps

module mlrr_front import mlrr_pkg::*; #(
  parameter int MAX_SOURCES = 16,
  parameter int MAX_LANES   = 4,
  parameter int SW          = 4,
  parameter int EW          = 2 + SW + MAX_LANES + MAX_SOURCES
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  mlrr_in_t      in_data,
  input  logic          q_full,
  output logic          q_push,
  output logic [EW-1:0] q_wdata
);

  logic [MAX_SOURCES-1:0] elig;
  logic [MAX_LANES-1:0]   free;
  logic [MASK_W-1:0]      elig16;
  logic                   req_ok;
  logic [SW-1:0]          req_idx;

  // Take a transfer whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // A source is eligible when present, ready and readable
  assign elig16 = in_data.head_present & in_data.head_ready & in_data.read_ready;

  // Sources past the mask width are never present
  for (genvar s = 0; s < MAX_SOURCES; s++) begin : g_elig
    if (s < MASK_W) begin : g_in
      assign elig[s] = elig16[s];
    end else begin : g_out
      assign elig[s] = 1'b0;
    end
  end

  // Lanes past the lane_free width are always busy
  for (genvar l = 0; l < MAX_LANES; l++) begin : g_free
    if (l < LANE_FREE_W) begin : g_in
      assign free[l] = in_data.lane_free[l];
    end else begin : g_out
      assign free[l] = 1'b0;
    end
  end

  // A requester beyond the source range can never be chosen
  assign req_ok  = (7'(in_data.requester) < 7'(MAX_SOURCES));
  assign req_idx = SW'(in_data.requester);

  assign q_wdata = {in_data.new_cycle, req_ok, req_idx, free, elig};

endmodule

[rtl/mlrr_queue.sv]
// Two-entry queue between the front end and the lane sequencer.
// No package dependencies.
`timescale 1ns / 1ps

module mlrr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[rtl/mlrr_back.sv]
// Lane sequencer: walks lanes in order, decides undecided lanes with a
// round-robin search, and holds the result register. Depends on mlrr_pkg.
`timescale 1ns / 1ps

module mlrr_back import mlrr_pkg::*; #(
  parameter int MAX_SOURCES = 16,
  parameter int MAX_LANES   = 4,
  parameter int SW          = 4,
  parameter int EW          = 2 + SW + MAX_LANES + MAX_SOURCES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic [EW-1:0]   q_rdata,
  input  logic [SC_W-1:0] source_count,
  input  logic [LC_W-1:0] lane_count,
  output logic            out_valid,
  input  logic            out_ready,
  output mlrr_out_t       out_data
);

  localparam int NW  = $clog2(MAX_SOURCES + 1);
  localparam int LIW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int LCW = $clog2(MAX_LANES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LANE,
    ST_SEARCH
  } state_t;

  state_t                 state_r;
  logic [MAX_LANES-1:0]   decided_r;
  logic [MAX_LANES-1:0]   has_r;
  logic [SW-1:0]          choice_r [MAX_LANES];
  logic [SW-1:0]          ptr_r;
  logic [SW-1:0]          wptr_r;
  logic [LCW-1:0]         ln_r;
  logic                   cur_req_ok_r;
  logic [SW-1:0]          cur_req_r;
  logic [MAX_LANES-1:0]   cur_free_r;
  logic [MAX_SOURCES-1:0] cur_elig_r;
  logic                   out_valid_r;
  mlrr_out_t              out_data_r;

  logic [NW-1:0]  n_eff;
  logic [LCW-1:0] nl_eff;
  logic [LIW-1:0] ln_idx;
  logic           lane_active;
  logic           lane_can_choose;
  logic           lane_match;
  logic           slot_free;
  logic           res_load;
  logic           need_reduce;
  logic [6:0]     start7;
  logic [SW-1:0]  start;
  logic           found;
  logic [SW-1:0]  pick;

  // Clamp the configuration to the built sizes
  always_comb begin
    if (7'(source_count) > 7'(MAX_SOURCES)) begin
      n_eff = NW'(MAX_SOURCES);
    end else begin
      n_eff = NW'(source_count);
    end
    if (5'(lane_count) > 5'(MAX_LANES)) begin
      nl_eff = LCW'(MAX_LANES);
    end else begin
      nl_eff = LCW'(lane_count);
    end
  end

  assign ln_idx          = LIW'(ln_r);
  assign lane_active     = (ln_r < nl_eff);
  assign lane_can_choose = cur_free_r[ln_idx] && (n_eff != '0);
  assign lane_match      = has_r[ln_idx] && cur_req_ok_r && (choice_r[ln_idx] == cur_req_r);
  assign slot_free       = !out_valid_r || out_ready;
  assign q_pop           = (state_r == ST_IDLE) && !q_empty;

  // Result register loads on a finished walk or a matching decided lane
  assign res_load = (state_r == ST_LANE) && slot_free &&
                    (!lane_active || (decided_r[ln_idx] && lane_match));

  // A stale pointer is brought below the source count by repeated subtraction
  assign need_reduce = (7'(wptr_r) >= 7'(n_eff));
  assign start7      = 7'(wptr_r) + 7'd1;
  assign start       = (start7 == 7'(n_eff)) ? '0 : SW'(start7);

  // Round-robin pick: lowest eligible at or after start, else lowest eligible
  always_comb begin
    logic           hi_found;
    logic [SW-1:0]  hi_pick;
    logic           lo_found;
    logic [SW-1:0]  lo_pick;
    hi_found = 1'b0;
    hi_pick  = '0;
    lo_found = 1'b0;
    lo_pick  = '0;
    for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
      if (cur_elig_r[i] && (7'(i) < 7'(n_eff))) begin
        lo_found = 1'b1;
        lo_pick  = SW'(i);
        if (7'(i) >= 7'(start)) begin
          hi_found = 1'b1;
          hi_pick  = SW'(i);
        end
      end
    end
    found = lo_found;
    pick  = hi_found ? hi_pick : lo_pick;
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      decided_r   <= '0;
      has_r       <= '0;
      ptr_r       <= '0;
      ln_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            {cur_req_ok_r, cur_req_r, cur_free_r, cur_elig_r} <= q_rdata[EW-2:0];
            if (q_rdata[EW-1]) begin
              decided_r <= '0;
            end
            ln_r    <= '0;
            state_r <= ST_LANE;
          end
        end
        ST_LANE: begin
          if (!lane_active) begin
            // Walked every lane in use without a grant
            if (slot_free) begin
              out_data_r <= '{granted: 1'b0, lane: '0};
              state_r    <= ST_IDLE;
            end
          end else if (!decided_r[ln_idx]) begin
            if (lane_can_choose) begin
              wptr_r  <= ptr_r;
              state_r <= ST_SEARCH;
            end else begin
              decided_r[ln_idx] <= 1'b1;
              has_r[ln_idx]     <= 1'b0;
            end
          end else if (lane_match) begin
            if (slot_free) begin
              out_data_r <= '{granted: 1'b1, lane: OUT_LANE_W'(ln_r)};
              state_r    <= ST_IDLE;
            end
          end else begin
            ln_r <= ln_r + LCW'(1);
          end
        end
        ST_SEARCH: begin
          if (need_reduce) begin
            wptr_r <= wptr_r - SW'(n_eff);
          end else begin
            decided_r[ln_idx] <= 1'b1;
            has_r[ln_idx]     <= found;
            if (found) begin
              choice_r[ln_idx] <= pick;
              ptr_r            <= pick;
            end
            state_r <= ST_LANE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pointer only ever holds a source index
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    7'(ptr_r) < 7'(MAX_SOURCES))
    else $error("round-robin pointer out of source range");

  // A finished search leaves its lane decided
  a_search_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && !need_reduce) |=> decided_r[$past(ln_idx)])
    else $error("search did not mark its lane decided");

  // Pointer reduction always makes progress
  a_reduce_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && need_reduce && n_eff != '0) |=> (wptr_r < $past(wptr_r)))
    else $error("pointer reduction stalled");

  // A decided lane that matches the requester produces a grant when the result slot is free
  a_grant_has_choice: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LANE && lane_active && decided_r[ln_idx] && lane_match && slot_free)
    |=> (out_valid_r && out_data_r.granted))
    else $error("matching lane did not produce a grant");

endmodule

[rtl/multi_lane_bus_round_robin_arbiter.sv]
// From transfer to result, a query passes the queue and the lane sequencer, which walks the
// lanes in order; a lane not yet decided is decided either without a search or by a search,
// and a stale pointer is first reduced by repeated source_count subtraction. Queries are
// handled one at a time: the next is taken only when idle, and a full result register stalls.
// Reset (synchronous, rst_n low): queue empty, all lanes undecided, pointer at 0,
// source_count 16, lane_count 1.
`timescale 1ns / 1ps

module multi_lane_bus_round_robin_arbiter import mlrr_pkg::*; #(
  parameter int MAX_SOURCES = 16,
  parameter int MAX_LANES   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mlrr_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mlrr_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(MAX_SOURCES);
  localparam int EW = 2 + SW + MAX_LANES + MAX_SOURCES;

  logic [SC_W-1:0] source_count_r;
  logic [LC_W-1:0] lane_count_r;
  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  logic [EW-1:0]   q_wdata;
  logic [EW-1:0]   q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_count_r <= SOURCE_COUNT_RST;
      lane_count_r   <= LANE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_COUNT: source_count_r <= SC_W'(cfg_wdata);
        CFG_LANE_COUNT:   lane_count_r   <= LC_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  mlrr_front #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_LANES   (MAX_LANES),
    .SW          (SW),
    .EW          (EW)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mlrr_queue #(
    .W (EW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mlrr_back #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_LANES   (MAX_LANES),
    .SW          (SW),
    .EW          (EW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_rdata      (q_rdata),
    .source_count (source_count_r),
    .lane_count   (lane_count_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

[verif/multi_lane_bus_round_robin_arbiter_tb.sv]
// Self-checking bench for the multi-lane round-robin bus arbiter: directed and random
// grant queries, config changes between idle phases, scoreboard on every grant answer.
// Depends on mlrr_pkg and multi_lane_bus_round_robin_arbiter.
`timescale 1ns / 1ps

module multi_lane_bus_round_robin_arbiter_tb;
  import mlrr_pkg::*;

  localparam int NUM_SRC       = 16;
  localparam int NUM_LANES     = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 88;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mlrr_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mlrr_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Pending queries, predicted grants, run bookkeeping
  mlrr_in_t  query_q[$];
  mlrr_out_t grant_q[$];
  mlrr_out_t want_grant;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        tx_gap_pct = 0;
  int        rx_stall_pct = 0;
  logic      tx_hold = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        stall_len;

  // Arbiter shadow state and config copy
  logic [SC_W-1:0] src_count_cfg = SOURCE_COUNT_RST;
  logic [LC_W-1:0] lane_count_cfg = LANE_COUNT_RST;
  logic            lane_done[NUM_LANES] = '{default: 1'b0};
  logic            lane_pick_valid[NUM_LANES] = '{default: 1'b0};
  logic [3:0]      lane_pick[NUM_LANES] = '{default: 4'd0};
  logic [3:0]      rr_last = 4'd0;

  multi_lane_bus_round_robin_arbiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walk lanes in order, deciding lazily, and return the first lane that picked req
  function automatic mlrr_out_t predict_grant(mlrr_in_t q);
    mlrr_out_t  r;
    logic [15:0] elig;
    int          n_src;
    int          n_lanes;
    int          idx;
    logic        hit;
    logic        picked;
    elig    = q.head_present & q.head_ready & q.read_ready;
    n_src   = (src_count_cfg > NUM_SRC) ? NUM_SRC : int'(src_count_cfg);
    n_lanes = (lane_count_cfg > NUM_LANES) ? NUM_LANES : int'(lane_count_cfg);
    r       = '0;
    hit     = 1'b0;
    if (q.new_cycle) begin
      for (int ln = 0; ln < NUM_LANES; ln++) lane_done[ln] = 1'b0;
    end
    for (int ln = 0; ln < n_lanes; ln++) begin
      if (!hit) begin
        if (!lane_done[ln]) begin
          lane_done[ln]       = 1'b1;
          lane_pick_valid[ln] = 1'b0;
          picked              = 1'b0;
          if (q.lane_free[ln] && n_src > 0) begin
            // search starts one past the last winner, wrapping at the source count
            for (int i = 0; i < n_src; i++) begin
              idx = (int'(rr_last) + i + 1) % n_src;
              if (!picked && elig[idx]) begin
                picked              = 1'b1;
                rr_last             = idx[3:0];
                lane_pick[ln]       = idx[3:0];
                lane_pick_valid[ln] = 1'b1;
              end
            end
          end
        end
        if (lane_pick_valid[ln] && lane_pick[ln] == q.requester) begin
          hit       = 1'b1;
          r.granted = 1'b1;
          r.lane    = ln[OUT_LANE_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Mostly zero; otherwise usually short, now and then long
  function automatic int draw_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] rand_mask(int pct);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) m[i] = ($urandom_range(0, 99) < pct);
    return m;
  endfunction

  // Query driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (query_q.size() > 0 && !tx_hold) begin
        in_valid <= 1'b1;
        in_data  <= query_q.pop_front();
        gap_left <= draw_gap(tx_gap_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = draw_gap(rx_stall_pct);
      out_ready  <= (stall_len == 0);
      stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
    end
  end

  // Monitor: predict on query transfer, check on grant transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) grant_q.push_back(predict_grant(in_data));
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected grant: granted=%0d lane=%0d", out_data.granted,
                     out_data.lane);
        end else begin
          want_grant = grant_q.pop_front();
          if (out_data.granted !== want_grant.granted || out_data.lane !== want_grant.lane)
          begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("grant mismatch: expected granted=%0d lane=%0d, got granted=%0d lane=%0d",
                       want_grant.granted, want_grant.lane, out_data.granted, out_data.lane);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (query_q.size() != 0 || in_valid || grant_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SOURCE_COUNT) src_count_cfg = val[SC_W-1:0];
    else lane_count_cfg = val[LC_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int sc, input int lc);
    wait_idle();
    write_reg(CFG_SOURCE_COUNT, sc[CFG_DATA_W-1:0]);
    write_reg(CFG_LANE_COUNT, lc[CFG_DATA_W-1:0]);
  endtask

  task automatic add_query(input logic nc, input logic [3:0] req, input logic [15:0] hp,
                           input logic [15:0] hr, input logic [15:0] rr,
                           input logic [3:0] lf);
    mlrr_in_t q;
    q.new_cycle    = nc;
    q.requester    = req;
    q.head_present = hp;
    q.head_ready   = hr;
    q.read_ready   = rr;
    q.lane_free    = lf;
    query_q.push_back(q);
  endtask

  // Bus cycles: a new_cycle query then more with the same masks, plus some noise
  task automatic add_bus_cycles(input int count);
    int          pushed;
    int          grp;
    int          dens;
    int          n_src;
    int          cands[$];
    logic [15:0] hp, hr, rr;
    logic [3:0]  lf;
    logic [3:0]  req;
    logic        nc;
    pushed = 0;
    n_src  = (src_count_cfg > NUM_SRC) ? NUM_SRC : int'(src_count_cfg);
    while (pushed < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_query(1'($urandom_range(0, 1)), 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 4'($urandom));
        pushed++;
      end else begin
        grp  = $urandom_range(1, 6);
        dens = $urandom_range(50, 100);
        hp   = rand_mask(dens);
        hr   = rand_mask(dens);
        rr   = rand_mask(dens);
        lf   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
        cands.delete();
        for (int i = 0; i < n_src; i++) if (hp[i] && hr[i] && rr[i]) cands.push_back(i);
        for (int k = 0; k < grp && pushed < count; k++) begin
          // first query of a phase sometimes keeps decisions from before the config write
          nc = (k == 0) ? (pushed > 0 || $urandom_range(0, 2) != 0) : 1'b0;
          if (cands.size() > 0 && $urandom_range(0, 9) < 7)
            req = 4'(cands[$urandom_range(0, cands.size() - 1)]);
          else
            req = 4'($urandom);
          add_query(nc, req, hp, hr, rr, lf);
          pushed++;
        end
      end
    end
  endtask

  initial begin
    int sc;
    int lc;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: 16 sources, one lane
    add_query(1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b0, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b1, 4'd15, 16'h0000, 16'h0000, 16'h0000, 4'h0);
    add_query(1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0);
    add_query(1'b1, 4'd15, 16'h8000, 16'hFFFF, 16'hFFFF, 4'h1);
    add_query(1'b1, 4'd0, 16'hFFFF, 16'h0001, 16'hFFFF, 4'h1);

    // Four lanes: walk through lanes, reuse cached choices, busy lane 0
    set_config(16, 4);
    add_query(1'b1, 4'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b0, 4'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b0, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b1, 4'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hA);

    // Counts above the maximum clamp
    set_config(31, 7);
    add_query(1'b1, 4'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b1, 4'd0, 16'h0001, 16'hFFFF, 16'hFFFF, 4'hF);

    // No sources
    set_config(0, 7);
    add_query(1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);

    // Park the pointer at 14, then shrink to 3 sources and no lanes
    set_config(16, 4);
    add_query(1'b1, 4'd14, 16'h4000, 16'hFFFF, 16'hFFFF, 4'hF);
    set_config(3, 0);
    add_query(1'b0, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    // lane count change mid-cycle: lane 0 still holds source 14
    wait_idle();
    write_reg(CFG_LANE_COUNT, 5'd2);
    add_query(1'b0, 4'd14, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b0, 4'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);

    // Single source, all lanes pick it
    set_config(1, 4);
    add_query(1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    add_query(1'b1, 4'd0, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'hF);

    // Random phases, each with its own config and idling mix
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        sc = 16;
        lc = 4;
      end else if (ph == RAND_PHASES - 1) begin
        sc = 1;
        lc = 1;
      end else begin
        case ($urandom_range(0, 19))
          0:       sc = 0;
          1:       sc = $urandom_range(17, 31);
          default: sc = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 19))
          0:       lc = 0;
          1:       lc = $urandom_range(5, 7);
          default: lc = $urandom_range(1, 4);
        endcase
      end
      set_config(sc, lc);
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 15;
        default: tx_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 15;
        default: rx_stall_pct = 50;
      endcase
      if (ph == 0) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      add_bus_cycles(PHASE_ITEMS);
      if (ph == 3) begin
        // hold the sender mid-phase until every grant is back
        do @(negedge clk); while (query_q.size() > PHASE_ITEMS / 2);
        tx_hold = 1'b1;
        do @(negedge clk); while (in_valid || grant_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        tx_hold = 1'b0;
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && grant_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
